// ===== src/bsm_pkg.sv =====
// Package for the bounding-sphere merge block: widths, word types and the
// controller state type. No dependencies.
package bsm_pkg;

    // Fraction bits of the fixed-point format; only the reset radius uses it.
    localparam int FRAC_BITS = 16;

    // Field widths of the words.
    localparam int CW = 32;
    localparam int RW = 31;

    // Center difference, squared distance and serial unit widths.
    localparam int DW     = CW + 1;
    localparam int MA_W   = DW;
    localparam int MB_W   = DW + 1;
    localparam int MP_W   = MA_W + MB_W;
    localparam int SQ_W   = 2 * DW;
    localparam int ROOT_W = DW;
    localparam int REM_W  = ROOT_W + 2;
    localparam int DEN_W  = ROOT_W + 1;
    localparam int Q_W    = DW;

    localparam int MUL_CNT_W  = $clog2(MB_W);
    localparam int DIV_CNT_W  = $clog2(Q_W);
    localparam int SQRT_CNT_W = $clog2(ROOT_W);

    localparam logic [RW-1:0] RESET_RADIUS = RW'(64'd1 << FRAC_BITS);
    localparam logic [RW-1:0] RAD_MAX      = {RW{1'b1}};

    typedef struct packed {
        logic                 load_new;
        logic signed [CW-1:0] other_center_x;
        logic signed [CW-1:0] other_center_y;
        logic signed [CW-1:0] other_center_z;
        logic        [RW-1:0] other_radius;
    } sphere_word_t;

    typedef struct packed {
        logic signed [CW-1:0] merged_center_x;
        logic signed [CW-1:0] merged_center_y;
        logic signed [CW-1:0] merged_center_z;
        logic        [RW-1:0] merged_radius;
        logic                 saturated;
    } merged_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_START,
        ST_SQ_WAIT,
        ST_SUM1,
        ST_SUM2,
        ST_CHECK,
        ST_SQRT_WAIT,
        ST_DECIDE,
        ST_MUL_START,
        ST_MUL_WAIT,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_WRITE
    } state_t;

endpackage

// ===== src/bsm_sermul.sv =====
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on bsm_pkg.
module bsm_sermul (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [bsm_pkg::MA_W-1:0] a,
    input  logic [bsm_pkg::MB_W-1:0] b,
    output logic                     done,
    output logic [bsm_pkg::MP_W-1:0] prod
);

    logic [bsm_pkg::MA_W-1:0]      a_reg;
    logic [bsm_pkg::MP_W-1:0]      p_reg;
    logic [bsm_pkg::MP_W-1:0]      p_next;
    logic [bsm_pkg::MUL_CNT_W-1:0] cnt_reg;
    logic [bsm_pkg::MUL_CNT_W-1:0] cnt_next;
    logic                          busy_reg;
    logic                          busy_next;
    logic                          done_reg;
    logic                          done_next;
    logic [bsm_pkg::MA_W-1:0]      addend;
    logic [bsm_pkg::MB_W-1:0]      upper_sum;

    // Add the multiplicand when the low bit is set, then shift right.
    always_comb
    begin
        addend    = p_reg[0] ? a_reg : '0;
        upper_sum = {1'b0, p_reg[bsm_pkg::MP_W-1:bsm_pkg::MB_W]} + {1'b0, addend};
        p_next    = {upper_sum, p_reg[bsm_pkg::MB_W-1:1]};
    end

    // Step counter and completion pulse.
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = bsm_pkg::MUL_CNT_W'(bsm_pkg::MB_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Operand and product shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            p_reg <= {{bsm_pkg::MA_W{1'b0}}, b};
        end
        else if (busy_reg)
        begin
            p_reg <= p_next;
        end
    end

    assign done = done_reg;
    assign prod = p_reg;

endmodule

// ===== src/bsm_serdiv.sv =====
// Restoring divider that produces one quotient bit per cycle.
// Depends on bsm_pkg; the quotient must fit in Q_W bits.
module bsm_serdiv (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [bsm_pkg::MP_W-1:0]  dividend,
    input  logic [bsm_pkg::DEN_W-1:0] divisor,
    output logic                      done,
    output logic [bsm_pkg::Q_W-1:0]   quotient
);

    logic [bsm_pkg::DEN_W-1:0]     d_reg;
    logic [bsm_pkg::DEN_W-1:0]     rem_reg;
    logic [bsm_pkg::Q_W-1:0]       q_reg;
    logic [bsm_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [bsm_pkg::DIV_CNT_W-1:0] cnt_next;
    logic                          busy_reg;
    logic                          busy_next;
    logic                          done_reg;
    logic                          done_next;
    logic [bsm_pkg::DEN_W:0]       shifted;
    logic [bsm_pkg::DEN_W:0]       diff;
    logic                          ge;

    // One trial subtraction per cycle.
    always_comb
    begin
        shifted = {rem_reg, q_reg[bsm_pkg::Q_W-1]};
        diff    = shifted - {1'b0, d_reg};
        ge      = (shifted >= {1'b0, d_reg});
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = bsm_pkg::DIV_CNT_W'(bsm_pkg::Q_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // The high dividend bits start as the partial remainder; the low bits
    // shift out while quotient bits shift in.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            d_reg   <= divisor;
            rem_reg <= dividend[bsm_pkg::MP_W-1:bsm_pkg::Q_W];
            q_reg   <= dividend[bsm_pkg::Q_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[bsm_pkg::DEN_W-1:0] : shifted[bsm_pkg::DEN_W-1:0];
            q_reg   <= {q_reg[bsm_pkg::Q_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== src/bsm_sqrt.sv =====
// Digit-by-digit floor square root, two radicand bits per cycle.
// Depends on bsm_pkg.
module bsm_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bsm_pkg::SQ_W-1:0]   radicand,
    output logic                       done,
    output logic [bsm_pkg::ROOT_W-1:0] root
);

    logic [bsm_pkg::SQ_W-1:0]       v_reg;
    logic [bsm_pkg::REM_W-1:0]      rem_reg;
    logic [bsm_pkg::ROOT_W-1:0]     root_reg;
    logic [bsm_pkg::SQRT_CNT_W-1:0] cnt_reg;
    logic [bsm_pkg::SQRT_CNT_W-1:0] cnt_next;
    logic                           busy_reg;
    logic                           busy_next;
    logic                           done_reg;
    logic                           done_next;
    logic [bsm_pkg::REM_W+1:0]      shifted;
    logic [bsm_pkg::REM_W+1:0]      trial;
    logic [bsm_pkg::REM_W+1:0]      diff;
    logic                           ge;

    // Bring down two bits and try to subtract 4*root + 1.
    always_comb
    begin
        shifted = {rem_reg, v_reg[bsm_pkg::SQ_W-1:bsm_pkg::SQ_W-2]};
        trial   = {2'b00, root_reg, 2'b01};
        diff    = shifted - trial;
        ge      = (shifted >= trial);
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = bsm_pkg::SQRT_CNT_W'(bsm_pkg::ROOT_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            v_reg    <= {v_reg[bsm_pkg::SQ_W-3:0], 2'b00};
            rem_reg  <= ge ? diff[bsm_pkg::REM_W-1:0] : shifted[bsm_pkg::REM_W-1:0];
            root_reg <= {root_reg[bsm_pkg::ROOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== src/bounding_sphere_merge.sv =====
// Running bounding-sphere merge in Q16.16. One word is taken at a time. A
// load goes straight to the write; a merge first squares the differences,
// then ends when one sphere contains the other, or takes the square root and
// ends when only the radius grows, or goes on to the offset products and the
// divide when the center moves. The next word is taken in the cycle after
// the write, which waits until the result register is free. The bit-serial
// units are shift-add multipliers (squares, then offset products), a square
// root and a divider, used in sequence. The result word waits in an output register.
// Depends on bsm_pkg, bsm_sermul, bsm_sqrt and bsm_serdiv.
module bounding_sphere_merge (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sphere_valid,
    output logic                  sphere_ready,
    input  bsm_pkg::sphere_word_t sphere,
    output logic                  merged_valid,
    input  logic                  merged_ready,
    output bsm_pkg::merged_word_t merged
);

    bsm_pkg::state_t state_reg;
    bsm_pkg::state_t state_next;

    // Kept sphere.
    logic signed [bsm_pkg::CW-1:0] kc_reg [3];
    logic signed [bsm_pkg::CW-1:0] kc_next [3];
    logic        [bsm_pkg::RW-1:0] kr_reg;
    logic        [bsm_pkg::RW-1:0] kr_next;
    logic                          sat_reg;
    logic                          sat_next;

    // Working registers of one merge.
    logic signed [bsm_pkg::CW-1:0]    oc_reg [3];
    logic        [bsm_pkg::RW-1:0]    orad_reg;
    logic signed [bsm_pkg::DW-1:0]    dx_reg [3];
    logic signed [bsm_pkg::CW-1:0]    rd_reg;
    logic        [bsm_pkg::SQ_W-1:0]  sum_reg;
    logic        [bsm_pkg::ROOT_W-1:0] len_reg;
    logic        [bsm_pkg::DEN_W-1:0] num_reg;
    logic        [bsm_pkg::DEN_W-1:0] den_reg;
    logic        [bsm_pkg::RW-1:0]    rnew_reg;

    // Output register.
    bsm_pkg::merged_word_t out_reg;
    logic                  out_valid_reg;

    // Control strobes.
    logic       accept;
    logic [3:0] mul_start;
    logic       sqrt_start;
    logic       div_start;
    logic       write_en;

    // Unit connections.
    logic [bsm_pkg::MA_W-1:0]   mul_a [4];
    logic [bsm_pkg::MB_W-1:0]   mul_b [4];
    logic [bsm_pkg::MP_W-1:0]   mul_prod [4];
    logic [3:0]                 mul_done;
    logic                       sqrt_done;
    logic [bsm_pkg::ROOT_W-1:0] sqrt_root;
    logic [bsm_pkg::Q_W-1:0]    div_q [3];
    logic [2:0]                 div_done;

    // Derived values.
    logic [bsm_pkg::DW-1:0]    dmag [3];
    logic [bsm_pkg::CW-1:0]    rdmag;
    logic                      contain;
    logic [bsm_pkg::DEN_W-1:0] lensum;
    logic                      move;
    logic [bsm_pkg::DEN_W-1:0] num_calc;
    logic [bsm_pkg::DEN_W-1:0] rsum;
    logic [bsm_pkg::ROOT_W-1:0] rhalf;
    logic                      rad_ovf;
    logic [bsm_pkg::RW-1:0]    rnew_calc;
    logic signed [bsm_pkg::CW+2:0] cand [3];
    logic signed [bsm_pkg::CW-1:0] newc [3];
    logic [2:0]                cen_ovf;

    assign accept = sphere_valid && sphere_ready;

    // Magnitudes of the center and radius differences.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dmag[i] = dx_reg[i][bsm_pkg::DW-1] ? bsm_pkg::DW'(-dx_reg[i])
                                                : bsm_pkg::DW'(dx_reg[i]);
        end
        rdmag = rd_reg[bsm_pkg::CW-1] ? bsm_pkg::CW'(-rd_reg) : bsm_pkg::CW'(rd_reg);
    end

    // Containment: squared distance no more than the squared radius gap.
    assign contain = (sum_reg <= mul_prod[3][bsm_pkg::SQ_W-1:0]);

    // Center move decision, offset fraction and new radius.
    always_comb
    begin
        lensum    = bsm_pkg::DEN_W'(len_reg) + bsm_pkg::DEN_W'(orad_reg);
        move      = (lensum > bsm_pkg::DEN_W'(kr_reg));
        num_calc  = bsm_pkg::DEN_W'(len_reg)
                  + {{(bsm_pkg::DEN_W-bsm_pkg::CW){rd_reg[bsm_pkg::CW-1]}}, rd_reg};
        rsum      = bsm_pkg::DEN_W'(len_reg) + bsm_pkg::DEN_W'(kr_reg)
                  + bsm_pkg::DEN_W'(orad_reg);
        rhalf     = rsum[bsm_pkg::DEN_W-1:1];
        rad_ovf   = |rhalf[bsm_pkg::ROOT_W-1:bsm_pkg::RW];
        rnew_calc = rad_ovf ? bsm_pkg::RAD_MAX : rhalf[bsm_pkg::RW-1:0];
    end

    // New centers: kept center plus or minus the quotient, clipped.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dx_reg[i][bsm_pkg::DW-1])
            begin
                cand[i] = {{3{kc_reg[i][bsm_pkg::CW-1]}}, kc_reg[i]}
                        - {2'b00, div_q[i]};
            end
            else
            begin
                cand[i] = {{3{kc_reg[i][bsm_pkg::CW-1]}}, kc_reg[i]}
                        + {2'b00, div_q[i]};
            end
            cen_ovf[i] = !((cand[i][bsm_pkg::CW+2:bsm_pkg::CW-1] == '0)
                        || (cand[i][bsm_pkg::CW+2:bsm_pkg::CW-1] == '1));
            if (!cen_ovf[i])
            begin
                newc[i] = cand[i][bsm_pkg::CW-1:0];
            end
            else if (cand[i][bsm_pkg::CW+2])
            begin
                newc[i] = {1'b1, {(bsm_pkg::CW-1){1'b0}}};
            end
            else
            begin
                newc[i] = {1'b0, {(bsm_pkg::CW-1){1'b1}}};
            end
        end
    end

    // Multiplier operands: squares first, then offset products.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mul_a[i] = dmag[i];
            mul_b[i] = (state_reg == bsm_pkg::ST_MUL_START) ? num_reg
                                                              : {1'b0, dmag[i]};
        end
        mul_a[3] = bsm_pkg::MA_W'(rdmag);
        mul_b[3] = bsm_pkg::MB_W'(rdmag);
    end

    // Serial units.
    genvar g;
    generate
        for (g = 0; g < 4; g++)
        begin : g_mul
            bsm_sermul u_mul (
                .clk   (clk),
                .rst_n (rst_n),
                .start (mul_start[g]),
                .a     (mul_a[g]),
                .b     (mul_b[g]),
                .done  (mul_done[g]),
                .prod  (mul_prod[g])
            );
        end
        for (g = 0; g < 3; g++)
        begin : g_div
            bsm_serdiv u_div (
                .clk      (clk),
                .rst_n    (rst_n),
                .start    (div_start),
                .dividend (mul_prod[g]),
                .divisor  (den_reg),
                .done     (div_done[g]),
                .quotient (div_q[g])
            );
        end
    endgenerate

    bsm_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sum_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bsm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = sphere.load_new ? bsm_pkg::ST_WRITE : bsm_pkg::ST_SQ_START;
                end
            end
            bsm_pkg::ST_SQ_START:  state_next = bsm_pkg::ST_SQ_WAIT;
            bsm_pkg::ST_SQ_WAIT:
            begin
                if (mul_done[0])
                begin
                    state_next = bsm_pkg::ST_SUM1;
                end
            end
            bsm_pkg::ST_SUM1:      state_next = bsm_pkg::ST_SUM2;
            bsm_pkg::ST_SUM2:      state_next = bsm_pkg::ST_CHECK;
            bsm_pkg::ST_CHECK:
            begin
                state_next = contain ? bsm_pkg::ST_WRITE : bsm_pkg::ST_SQRT_WAIT;
            end
            bsm_pkg::ST_SQRT_WAIT:
            begin
                if (sqrt_done)
                begin
                    state_next = bsm_pkg::ST_DECIDE;
                end
            end
            bsm_pkg::ST_DECIDE:
            begin
                state_next = move ? bsm_pkg::ST_MUL_START : bsm_pkg::ST_WRITE;
            end
            bsm_pkg::ST_MUL_START: state_next = bsm_pkg::ST_MUL_WAIT;
            bsm_pkg::ST_MUL_WAIT:
            begin
                if (mul_done[0])
                begin
                    state_next = bsm_pkg::ST_DIV_START;
                end
            end
            bsm_pkg::ST_DIV_START: state_next = bsm_pkg::ST_DIV_WAIT;
            bsm_pkg::ST_DIV_WAIT:
            begin
                if (div_done[0])
                begin
                    state_next = bsm_pkg::ST_WRITE;
                end
            end
            bsm_pkg::ST_WRITE:
            begin
                if (!out_valid_reg || merged_ready)
                begin
                    state_next = bsm_pkg::ST_IDLE;
                end
            end
            default:               state_next = bsm_pkg::ST_IDLE;
        endcase
    end

    // Controller outputs.
    always_comb
    begin
        sphere_ready = 1'b0;
        mul_start    = '0;
        sqrt_start   = 1'b0;
        div_start    = 1'b0;
        write_en     = 1'b0;
        unique case (state_reg)
            bsm_pkg::ST_IDLE:      sphere_ready = 1'b1;
            bsm_pkg::ST_SQ_START:  mul_start = 4'b1111;
            bsm_pkg::ST_CHECK:     sqrt_start = !contain;
            bsm_pkg::ST_MUL_START: mul_start = 4'b0111;
            bsm_pkg::ST_DIV_START: div_start = 1'b1;
            bsm_pkg::ST_WRITE:     write_en = !out_valid_reg || merged_ready;
            default:
            begin
                sphere_ready = 1'b0;
            end
        endcase
    end

    // Kept sphere and saturation flag updates.
    always_comb
    begin
        kc_next  = kc_reg;
        kr_next  = kr_reg;
        sat_next = sat_reg;
        if (accept)
        begin
            sat_next = 1'b0;
            if (sphere.load_new)
            begin
                kc_next[0] = sphere.other_center_x;
                kc_next[1] = sphere.other_center_y;
                kc_next[2] = sphere.other_center_z;
                kr_next    = sphere.other_radius;
            end
        end
        else if (state_reg == bsm_pkg::ST_CHECK)
        begin
            if (contain && !rd_reg[bsm_pkg::CW-1] && (rd_reg != '0))
            begin
                kc_next = oc_reg;
                kr_next = orad_reg;
            end
        end
        else if (state_reg == bsm_pkg::ST_DECIDE)
        begin
            sat_next = rad_ovf;
            if (!move)
            begin
                kr_next = rnew_calc;
            end
        end
        else if ((state_reg == bsm_pkg::ST_DIV_WAIT) && div_done[0])
        begin
            kc_next  = newc;
            kr_next  = rnew_reg;
            sat_next = sat_reg || (|cen_ovf);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bsm_pkg::ST_IDLE;
            kc_reg[0]     <= '0;
            kc_reg[1]     <= '0;
            kc_reg[2]     <= '0;
            kr_reg        <= bsm_pkg::RESET_RADIUS;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kc_reg    <= kc_next;
            kr_reg    <= kr_next;
            sat_reg   <= sat_next;
            if (write_en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (merged_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers and output word.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            oc_reg[0] <= sphere.other_center_x;
            oc_reg[1] <= sphere.other_center_y;
            oc_reg[2] <= sphere.other_center_z;
            orad_reg  <= sphere.other_radius;
            dx_reg[0] <= {sphere.other_center_x[bsm_pkg::CW-1], sphere.other_center_x}
                       - {kc_reg[0][bsm_pkg::CW-1], kc_reg[0]};
            dx_reg[1] <= {sphere.other_center_y[bsm_pkg::CW-1], sphere.other_center_y}
                       - {kc_reg[1][bsm_pkg::CW-1], kc_reg[1]};
            dx_reg[2] <= {sphere.other_center_z[bsm_pkg::CW-1], sphere.other_center_z}
                       - {kc_reg[2][bsm_pkg::CW-1], kc_reg[2]};
            rd_reg    <= {1'b0, sphere.other_radius} - {1'b0, kr_reg};
        end
        if (state_reg == bsm_pkg::ST_SUM1)
        begin
            sum_reg <= bsm_pkg::SQ_W'(mul_prod[0]) + bsm_pkg::SQ_W'(mul_prod[1]);
        end
        else if (state_reg == bsm_pkg::ST_SUM2)
        begin
            sum_reg <= sum_reg + bsm_pkg::SQ_W'(mul_prod[2]);
        end
        if ((state_reg == bsm_pkg::ST_SQRT_WAIT) && sqrt_done)
        begin
            len_reg <= sqrt_root;
        end
        if (state_reg == bsm_pkg::ST_DECIDE)
        begin
            num_reg  <= num_calc;
            den_reg  <= {len_reg, 1'b0};
            rnew_reg <= rnew_calc;
        end
        if (write_en)
        begin
            out_reg.merged_center_x <= kc_reg[0];
            out_reg.merged_center_y <= kc_reg[1];
            out_reg.merged_center_z <= kc_reg[2];
            out_reg.merged_radius   <= kr_reg;
            out_reg.saturated       <= sat_reg;
        end
    end

    assign merged_valid = out_valid_reg;
    assign merged       = out_reg;

    // The three axis units run in lockstep.
    a_axis_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done[0] |-> (mul_done[1] && mul_done[2]))
        else $error("axis multipliers out of step");

    // An offset never exceeds the center difference, since t is at most one.
    a_offset_bound: assert property (@(posedge clk) disable iff (!rst_n)
        div_done[0] |-> (div_q[0] <= dmag[0]))
        else $error("center offset exceeds center distance");

    // A result word appears only after the write state.
    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(merged_valid) |-> $past(state_reg == bsm_pkg::ST_WRITE))
        else $error("result word without write state");

endmodule

// ===== sim/tb_bounding_sphere_merge.sv =====
// Testbench for bounding_sphere_merge: drives sphere words, predicts each merged
// word with a behavioral model, checks them in order; needs bsm_pkg and the DUT.
module tb_bounding_sphere_merge;

    logic                  clk;
    logic                  rst_n;
    logic                  sphere_valid;
    logic                  sphere_ready;
    bsm_pkg::sphere_word_t sphere;
    logic                  merged_valid;
    logic                  merged_ready;
    bsm_pkg::merged_word_t merged;

    // Pending stimulus words and expected merged words.
    bsm_pkg::sphere_word_t pending_spheres[$];
    bsm_pkg::merged_word_t expected_merges[$];

    // Predicted kept sphere.
    logic signed [63:0] cur_cx;
    logic signed [63:0] cur_cy;
    logic signed [63:0] cur_cz;
    logic signed [63:0] cur_rad;

    int  n_errors;
    bit  stim_done;
    bit  hold_sender;
    bit  no_idle;

    bounding_sphere_merge u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sphere_valid (sphere_valid),
        .sphere_ready (sphere_ready),
        .sphere       (sphere),
        .merged_valid (merged_valid),
        .merged_ready (merged_ready),
        .merged       (merged)
    );

    always #5 clk = ~clk;

    // Floor square root of a 66-bit value, bit by bit.
    function automatic logic [63:0] isqrt(logic [127:0] v);
        logic [63:0]  r;
        logic [63:0]  c;
        r = 0;
        for (int b = 34; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= v)
                r = c;
        end
        return r;
    endfunction

    // Moves one center coordinate by d * num / den, truncated toward zero.
    function automatic logic signed [63:0] shift_axis(logic signed [63:0] k,
            logic signed [63:0] d, logic [63:0] num, logic [63:0] den, ref bit sat);
        logic [127:0]       mag;
        logic [127:0]       q;
        logic signed [63:0] v;
        mag = (d < 0) ? 128'(-d) : 128'(d);
        q = (mag * {64'd0, num}) / {64'd0, den};
        v = (d < 0) ? k - $signed(q[63:0]) : k + $signed(q[63:0]);
        if (v > 64'sd2147483647)
        begin
            v = 64'sd2147483647;
            sat = 1;
        end
        if (v < -64'sd2147483648)
        begin
            v = -64'sd2147483648;
            sat = 1;
        end
        return v;
    endfunction

    // Applies one word to the kept sphere and queues the merged word it gives.
    function automatic void merge_sphere(bsm_pkg::sphere_word_t w);
        logic signed [63:0]    ox;
        logic signed [63:0]    oy;
        logic signed [63:0]    oz;
        logic signed [63:0]    orad;
        logic signed [63:0]    dx;
        logic signed [63:0]    dy;
        logic signed [63:0]    dz;
        logic signed [63:0]    rd;
        logic signed [63:0]    nr;
        logic [127:0]          dist2;
        logic [127:0]          rd2;
        logic [63:0]           len;
        bsm_pkg::merged_word_t m;
        bit                    sat;
        ox = w.other_center_x;
        oy = w.other_center_y;
        oz = w.other_center_z;
        orad = {33'd0, w.other_radius};
        sat = 0;
        if (w.load_new)
        begin
            cur_cx = ox;
            cur_cy = oy;
            cur_cz = oz;
            cur_rad = orad;
        end
        else
        begin
            dx = ox - cur_cx;
            dy = oy - cur_cy;
            dz = oz - cur_cz;
            rd = orad - cur_rad;
            dist2 = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy) + 128'(dz) * 128'(dz);
            rd2 = 128'(rd) * 128'(rd);
            if (rd2 >= dist2)
            begin
                // One sphere holds the other; the larger one stays.
                if (rd > 0)
                begin
                    cur_cx = ox;
                    cur_cy = oy;
                    cur_cz = oz;
                    cur_rad = orad;
                end
            end
            else
            begin
                len = isqrt(dist2);
                if ($signed(len) + orad > cur_rad && len > 0)
                begin
                    cur_cx = shift_axis(cur_cx, dx, len + rd, len << 1, sat);
                    cur_cy = shift_axis(cur_cy, dy, len + rd, len << 1, sat);
                    cur_cz = shift_axis(cur_cz, dz, len + rd, len << 1, sat);
                end
                nr = ($signed(len) + cur_rad + orad) >>> 1;
                if (nr > 64'sd2147483647)
                begin
                    nr = 64'sd2147483647;
                    sat = 1;
                end
                cur_rad = nr;
            end
        end
        m.merged_center_x = cur_cx[31:0];
        m.merged_center_y = cur_cy[31:0];
        m.merged_center_z = cur_cz[31:0];
        m.merged_radius = cur_rad[30:0];
        m.saturated = sat;
        expected_merges.push_back(m);
    endfunction

    function automatic bsm_pkg::sphere_word_t make_sphere(bit ld, logic [31:0] x,
            logic [31:0] y, logic [31:0] z, logic [30:0] r);
        bsm_pkg::sphere_word_t w;
        w.load_new = ld;
        w.other_center_x = x;
        w.other_center_y = y;
        w.other_center_z = z;
        w.other_radius = r;
        return w;
    endfunction

    // Random coordinate: mostly near zero, sometimes any value or near the extremes.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            2: return 32'($signed($urandom_range(0, 20000)) - 10000) << 8;
            default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 50)
                                                 : 32'h8000_0000 + $urandom_range(0, 50);
        endcase
    endfunction

    function automatic logic [30:0] rand_radius();
        case ($urandom_range(0, 3))
            0: return 31'($urandom);
            1: return 31'($urandom_range(0, 2000000));
            2: return 31'h7FFF_FFFF - 31'($urandom_range(0, 100));
            default: return 31'($urandom_range(0, 100));
        endcase
    endfunction

    // Sender: presents queued words, idling at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sphere_valid <= 1'b0;
            sphere <= '0;
        end
        else if (!sphere_valid || sphere_ready)
        begin
            if (pending_spheres.size() > 0 && !hold_sender
                    && (no_idle || $urandom_range(0, 99) >= 31))
            begin
                sphere_valid <= 1'b1;
                sphere <= pending_spheres.pop_front();
            end
            else
                sphere_valid <= 1'b0;
        end
    end

    // Predict on acceptance.
    always @(posedge clk)
    begin
        if (rst_n && sphere_valid && sphere_ready)
            merge_sphere(sphere);
    end

    // Receiver: stalls at random and checks each merged word.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            merged_ready <= 1'b0;
        else
        begin
            if (merged_valid && merged_ready)
            begin
                if (expected_merges.size() == 0)
                begin
                    $error("merged word with nothing expected");
                    n_errors++;
                end
                else
                begin
                    bsm_pkg::merged_word_t e;
                    e = expected_merges.pop_front();
                    if (merged.merged_center_x !== e.merged_center_x)
                    begin
                        $error("merged_center_x exp %0d got %0d",
                               e.merged_center_x, merged.merged_center_x);
                        n_errors++;
                    end
                    if (merged.merged_center_y !== e.merged_center_y)
                    begin
                        $error("merged_center_y exp %0d got %0d",
                               e.merged_center_y, merged.merged_center_y);
                        n_errors++;
                    end
                    if (merged.merged_center_z !== e.merged_center_z)
                    begin
                        $error("merged_center_z exp %0d got %0d",
                               e.merged_center_z, merged.merged_center_z);
                        n_errors++;
                    end
                    if (merged.merged_radius !== e.merged_radius)
                    begin
                        $error("merged_radius exp %0d got %0d",
                               e.merged_radius, merged.merged_radius);
                        n_errors++;
                    end
                    if (merged.saturated !== e.saturated)
                    begin
                        $error("saturated exp %0d got %0d", e.saturated, merged.saturated);
                        n_errors++;
                    end
                end
            end
            merged_ready <= no_idle || $urandom_range(0, 99) >= 31;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        clk = 0;
        rst_n = 0;
        n_errors = 0;
        stim_done = 0;
        hold_sender = 0;
        no_idle = 0;
        cur_cx = 0;
        cur_cy = 0;
        cur_cz = 0;
        cur_rad = 64'sd1 << bsm_pkg::FRAC_BITS;
        sphere_valid = 0;
        sphere = '0;
        merged_ready = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words: from reset state, containment both ways, extremes.
        pending_spheres.push_back(make_sphere(0, 32'd0, 32'd0, 32'd0, 31'd100));
        pending_spheres.push_back(make_sphere(0, 32'd10, 32'd0, 32'd0, 31'd200000));
        pending_spheres.push_back(make_sphere(0, 32'd1000000, 32'd0, 32'd0, 31'd65536));
        pending_spheres.push_back(make_sphere(0, 32'd0, 32'd300000, 32'd0, 31'd0));
        pending_spheres.push_back(make_sphere(1, 32'd0, 32'd0, 32'd0, 31'd0));
        pending_spheres.push_back(make_sphere(0, 32'd0, 32'd0, 32'd0, 31'd0));
        pending_spheres.push_back(make_sphere(0, 32'd1, 32'd0, 32'd0, 31'd0));
        pending_spheres.push_back(make_sphere(1, 32'h8000_0000, 32'h8000_0000,
                                              32'h8000_0000, 31'h7FFF_FFFF));
        pending_spheres.push_back(make_sphere(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                              32'h7FFF_FFFF, 31'h7FFF_FFFF));
        pending_spheres.push_back(make_sphere(0, 32'h8000_0000, 32'h7FFF_FFFF,
                                              32'h8000_0000, 31'h7FFF_FFFF));
        pending_spheres.push_back(make_sphere(1, 32'd0, 32'd0, 32'd0, 31'd1000));
        pending_spheres.push_back(make_sphere(0, 32'd5000, 32'hFFFF_F000, 32'd7, 31'd10));
        pending_spheres.push_back(make_sphere(0, 32'hFFFF_0000, 32'd3, 32'd65536,
                                              31'd400000));
        pending_spheres.push_back(make_sphere(1, 32'h7FFF_FFFF, 32'd0, 32'd0, 31'd5));
        pending_spheres.push_back(make_sphere(0, 32'h8000_0000, 32'd0, 32'd0, 31'd5));
        pending_spheres.push_back(make_sphere(0, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
                                              32'h5555_5555, 31'h5555_5555));

        // Wait until every result is back before the random part.
        wait (pending_spheres.size() == 0);
        hold_sender = 1;
        wait (expected_merges.size() == 0 && !sphere_valid);
        hold_sender = 0;

        // Random words: mostly merges, occasional loads; a stretch without idling.
        for (int i = 0; i < 800; i++)
        begin
            if (i == 300)
            begin
                wait (pending_spheres.size() == 0);
                no_idle = 1;
            end
            if (i == 420)
            begin
                wait (pending_spheres.size() == 0);
                no_idle = 0;
            end
            pending_spheres.push_back(make_sphere($urandom_range(0, 9) == 0,
                                      rand_coord(), rand_coord(), rand_coord(),
                                      rand_radius()));
        end
        stim_done = 1;

        wait (pending_spheres.size() == 0 && !sphere_valid && expected_merges.size() == 0);
        repeat (200) @(posedge clk);
        if (n_errors == 0 && expected_merges.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: 816 words plus stalls, with a wide margin.
    initial
    begin
        #20000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
